// ===== hdl/assert_macros.svh =====
// Assertion macros used by the RTL of the file allocator.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define ASSERT_CLK_RST(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

// ===== hdl/fcfa_pkg.sv =====
// Types and constants of the file allocation table chain allocator.
// Depends on nothing; imported by the allocator core and its testbench.
package fcfa_pkg;
   localparam logic [1:0] OP_CREATE = 2'd0;
   localparam logic [1:0] OP_APPEND = 2'd1;
   localparam logic [1:0] OP_DELETE = 2'd2;
   localparam logic [1:0] OP_IGNORED = 2'd3;
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_EXISTS    = 2'd1;
   localparam logic [1:0] ST_FULL      = 2'd2;
   localparam logic [1:0] ST_NOT_FOUND = 2'd3;
   localparam int KEY_W = 64;
   localparam int DATA_W = 8;
   localparam int BLKOUT_W = 7;
   typedef logic [1:0] op_type;
   typedef logic [1:0] status_type;
endpackage

// ===== hdl/fat_chain_file_allocator_core.sv =====
// Directory, allocation table and data store of a small flat file store.
// Depends on fcfa_pkg and assert_macros.svh.
//
// One request channel (req_) carries an operation, a name key, a data byte and
// a deep-erase flag; one response channel (rsp_) returns a status and a block
// index. Both use valid and stall; a transfer happens when valid is high and
// stall is low. Exactly one response follows each request.
// After reset a clearing pass marks every table entry free; no request is taken
// during it. Requests are then handled one at a time. The slowest request is an
// append to a long chain: the directory is scanned one entry a cycle through its
// memory read port, the chain is walked link by link, and the table is then
// searched one entry a cycle for a free block. A delete scans the directory and
// frees the chain link by link; a create scans the directory, then the table.
// The response sits in an output register; a stalled response holds, and the
// next request may be taken while it waits, but is processed only after the
// response has been transferred.
`include "assert_macros.svh"
module fat_chain_file_allocator_core #(
   parameter int NUM_BLOCKS = 128,
   parameter int DIR_ENTRIES = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  fcfa_pkg::op_type              req_operation,
   input  logic [fcfa_pkg::KEY_W-1:0]    req_name_key,
   input  logic [fcfa_pkg::DATA_W-1:0]   req_data_byte,
   input  logic                          req_deep_erase,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output fcfa_pkg::status_type          rsp_status,
   output logic [fcfa_pkg::BLKOUT_W-1:0] rsp_block_index
);
   import fcfa_pkg::*;

   localparam int BW = $clog2(NUM_BLOCKS);
   localparam int DW = $clog2(DIR_ENTRIES);
   localparam int FW = BW + 2;
   localparam logic [FW-1:0] FAT_END    = FW'(NUM_BLOCKS);
   localparam logic [FW-1:0] FAT_FREE   = FW'(NUM_BLOCKS + 1);
   localparam logic [FW-1:0] FAT_UNUSED = FW'(NUM_BLOCKS + 2);

   localparam logic [3:0] S_CLEAR = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_FIND  = 4'd2;
   localparam logic [3:0] S_DISP  = 4'd3;
   localparam logic [3:0] S_FBLK  = 4'd4;
   localparam logic [3:0] S_FSLOT = 4'd5;
   localparam logic [3:0] S_START = 4'd6;
   localparam logic [3:0] S_WALK  = 4'd7;
   localparam logic [3:0] S_DEL   = 4'd8;
   localparam logic [3:0] S_RESP  = 4'd9;

   logic [FW-1:0] fat_mem [NUM_BLOCKS];
   logic [DATA_W-1:0] data_mem [NUM_BLOCKS];
   logic [KEY_W-1:0] name_mem [DIR_ENTRIES];
   logic [BW-1:0] start_mem [DIR_ENTRIES];
   logic [DIR_ENTRIES-1:0] valid_ff;

   logic [3:0] state_ff;
   logic [BW:0] cnt_ff;
   logic [DW:0] dcnt_ff;
   logic [BW-1:0] fat_raddr;
   logic [FW-1:0] fat_rd_ff;
   logic [DW-1:0] dir_raddr;
   logic [KEY_W-1:0] name_rd_ff;
   logic [BW-1:0] start_rd_ff;
   logic rd_pend_ff;
   logic fat_we;
   logic [BW-1:0] fat_waddr;
   logic [FW-1:0] fat_wdata;
   logic data_we;
   logic [BW-1:0] data_waddr;
   logic [DATA_W-1:0] data_wdata;

   logic have_req_ff;
   op_type op_ff;
   logic [KEY_W-1:0] key_ff;
   logic [DATA_W-1:0] byte_ff;
   logic deep_ff;
   logic found_ff;
   logic [DW-1:0] slot_ff;
   logic [BW-1:0] blk_ff;
   logic [BW-1:0] cur_ff;
   logic [BW-1:0] start_ff;
   logic rsp_valid_ff;
   status_type status_ff;
   logic [BLKOUT_W-1:0] blkout_ff;

   assign req_stall = have_req_ff || (state_ff == S_CLEAR);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = status_ff;
   assign rsp_block_index = blkout_ff;

   // Combinational address and write controls for the memories.
   always_comb begin
      fat_raddr = cnt_ff[BW-1:0];
      dir_raddr = dcnt_ff[DW-1:0];
      fat_we = 1'b0;
      fat_waddr = cnt_ff[BW-1:0];
      fat_wdata = FAT_FREE;
      data_we = 1'b0;
      data_waddr = cur_ff;
      data_wdata = '0;
      unique case (state_ff)
         S_CLEAR: fat_we = 1'b1;
         S_START, S_WALK, S_DEL: fat_raddr = cur_ff;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (fat_we) fat_mem[fat_waddr] <= fat_wdata;
      if (data_we) data_mem[data_waddr] <= data_wdata;
      fat_rd_ff <= fat_mem[fat_raddr];
      name_rd_ff <= name_mem[dir_raddr];
      start_rd_ff <= start_mem[dir_raddr];
      if (state_ff == S_DISP && op_ff == OP_CREATE && found_ff) begin
         name_mem[slot_ff] <= key_ff;
         start_mem[slot_ff] <= blk_ff;
      end
      if (state_ff == S_DISP && op_ff == OP_APPEND && found_ff && cur_ff != start_ff) begin
         fat_mem[blk_ff] <= FAT_END;
         fat_mem[cur_ff] <= {2'b00, blk_ff};
         data_mem[blk_ff] <= byte_ff;
      end
      if (state_ff == S_DEL && rd_pend_ff) begin
         fat_mem[cur_ff] <= FAT_FREE;
         if (deep_ff) data_mem[cur_ff] <= '0;
      end
      if (state_ff == S_START && rd_pend_ff && op_ff == OP_CREATE) begin
         fat_mem[blk_ff] <= FAT_UNUSED;
      end
      if (state_ff == S_START && rd_pend_ff && op_ff == OP_APPEND
          && fat_rd_ff == FAT_UNUSED) begin
         fat_mem[cur_ff] <= FAT_END;
         data_mem[cur_ff] <= byte_ff;
      end
   end

   // Sequencer. Phases: clearing pass, idle, find entry (dir scan), free block scan,
   // free slot scan, dispatch, start read, chain walk, free walk, response.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         cnt_ff <= '0;
         dcnt_ff <= '0;
         valid_ff <= '0;
         have_req_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rd_pend_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
         if (req_valid && !req_stall) begin
            have_req_ff <= 1'b1;
            op_ff <= req_operation;
            key_ff <= req_name_key;
            byte_ff <= req_data_byte;
            deep_ff <= req_deep_erase;
         end
         unique case (state_ff)
            S_CLEAR: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == (BW+1)'(NUM_BLOCKS - 1)) state_ff <= S_IDLE;
            end
            S_IDLE: begin
               if (have_req_ff && !rsp_valid_ff) begin
                  dcnt_ff <= '0;
                  cnt_ff <= '0;
                  found_ff <= 1'b0;
                  rd_pend_ff <= 1'b0;
                  blkout_ff <= '0;
                  status_ff <= ST_OK;
                  state_ff <= (op_ff == OP_CREATE || op_ff == OP_APPEND
                               || op_ff == OP_DELETE) ? S_FIND : S_RESP;
               end
            end
            S_FIND: begin
               rd_pend_ff <= 1'b1;
               slot_ff <= dcnt_ff[DW-1:0] - 1'b1;
               if (rd_pend_ff && valid_ff[DW'(dcnt_ff - 1'b1)] && name_rd_ff == key_ff) begin
                  found_ff <= 1'b1;
                  start_ff <= start_rd_ff;
                  cur_ff <= start_rd_ff;
                  rd_pend_ff <= 1'b0;
                  if (op_ff == OP_CREATE) begin
                     status_ff <= ST_EXISTS;
                     state_ff <= S_RESP;
                  end else begin
                     state_ff <= S_START;
                  end
               end else if (dcnt_ff == (DW+1)'(DIR_ENTRIES)) begin
                  rd_pend_ff <= 1'b0;
                  if (op_ff == OP_CREATE) begin
                     cnt_ff <= '0;
                     state_ff <= S_FBLK;
                  end else begin
                     status_ff <= ST_NOT_FOUND;
                     state_ff <= S_RESP;
                  end
               end else begin
                  dcnt_ff <= dcnt_ff + 1'b1;
               end
            end
            S_FBLK: begin
               rd_pend_ff <= 1'b1;
               if (rd_pend_ff && fat_rd_ff == FAT_FREE) begin
                  blk_ff <= BW'(cnt_ff - 1'b1);
                  rd_pend_ff <= 1'b0;
                  if (op_ff == OP_CREATE) state_ff <= S_FSLOT;
                  else begin
                     found_ff <= 1'b1;
                     state_ff <= S_DISP;
                  end
               end else if (cnt_ff == (BW+1)'(NUM_BLOCKS)) begin
                  status_ff <= ST_FULL;
                  state_ff <= S_RESP;
               end else begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            S_FSLOT: begin
               found_ff <= 1'b0;
               for (int i = DIR_ENTRIES - 1; i >= 0; i--) begin
                  if (!valid_ff[i]) begin
                     found_ff <= 1'b1;
                     slot_ff <= DW'(i);
                  end
               end
               state_ff <= S_DISP;
            end
            S_DISP: begin
               if (op_ff == OP_CREATE) begin
                  if (found_ff) begin
                     valid_ff[slot_ff] <= 1'b1;
                     blkout_ff <= BLKOUT_W'(blk_ff);
                     cur_ff <= blk_ff;
                     rd_pend_ff <= 1'b1;
                     state_ff <= S_START;
                  end else begin
                     status_ff <= ST_FULL;
                     state_ff <= S_RESP;
                  end
               end else begin
                  blkout_ff <= BLKOUT_W'(blk_ff);
                  state_ff <= S_RESP;
               end
            end
            S_START: begin
               if (op_ff == OP_CREATE) begin
                  state_ff <= S_RESP;
               end else if (!rd_pend_ff) begin
                  rd_pend_ff <= 1'b1;
               end else if (op_ff == OP_DELETE) begin
                  rd_pend_ff <= 1'b0;
                  cnt_ff <= '0;
                  state_ff <= S_DEL;
               end else if (fat_rd_ff == FAT_UNUSED) begin
                  blkout_ff <= BLKOUT_W'(cur_ff);
                  state_ff <= S_RESP;
               end else begin
                  rd_pend_ff <= 1'b0;
                  cnt_ff <= '0;
                  state_ff <= S_WALK;
               end
            end
            S_WALK: begin
               rd_pend_ff <= ~rd_pend_ff;
               if (rd_pend_ff) begin
                  cnt_ff <= cnt_ff + 1'b1;
                  if (fat_rd_ff < FAT_END && cnt_ff != (BW+1)'(NUM_BLOCKS)) begin
                     cur_ff <= fat_rd_ff[BW-1:0];
                  end else begin
                     start_ff <= ~cur_ff;
                     cnt_ff <= '0;
                     rd_pend_ff <= 1'b0;
                     state_ff <= S_FBLK;
                  end
               end
            end
            S_DEL: begin
               rd_pend_ff <= ~rd_pend_ff;
               if (rd_pend_ff) begin
                  cnt_ff <= cnt_ff + 1'b1;
                  if (fat_rd_ff < FAT_END && cnt_ff != (BW+1)'(NUM_BLOCKS - 1)) begin
                     cur_ff <= fat_rd_ff[BW-1:0];
                  end else begin
                     valid_ff[slot_ff] <= 1'b0;
                     state_ff <= S_RESP;
                  end
               end
            end
            S_RESP: begin
               rsp_valid_ff <= 1'b1;
               have_req_ff <= 1'b0;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   `ASSERT_CLK(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid, "response dropped while stalled")
   `ASSERT_CLK(a_rsp_after_req, clock, reset, $rose(rsp_valid) |-> $past(state_ff) == S_RESP, "response without request")
   `ASSERT_CLK(a_no_accept_clear, clock, reset, state_ff == S_CLEAR |-> req_stall, "request taken during clearing pass")
endmodule

// ===== dv/fat_chain_file_allocator_core_tb.sv =====
// Self-checking testbench of the file allocation table chain allocator core.
// Depends on fcfa_pkg and the core; a scoreboard class predicts each response.
`timescale 1ns / 1ps
module fat_chain_file_allocator_core_tb;
   import fcfa_pkg::*;

   localparam int NBLK = 128;
   localparam int NDIR = 32;
   localparam int FREE_E = NBLK + 1;
   localparam int END_E = NBLK;
   localparam int UNUSED_E = NBLK + 2;
   localparam int LIMIT = 40000;

   typedef struct packed {
      status_type status;
      logic [BLKOUT_W-1:0] blk;
   } fs_result_type;

   class fs_scoreboard;
      bit valid_q[NDIR];
      logic [63:0] name_q[NDIR];
      int start_q[NDIR];
      int fat_q[NBLK];
      fs_result_type pending[$];
      int fails;

      function new();
         foreach (valid_q[i]) valid_q[i] = 0;
         foreach (fat_q[i]) fat_q[i] = FREE_E;
         fails = 0;
      endfunction

      function int lookup(logic [63:0] key);
         for (int i = 0; i < NDIR; i++)
            if (valid_q[i] && name_q[i] == key) return i;
         return -1;
      endfunction

      function int free_block();
         for (int i = 0; i < NBLK; i++)
            if (fat_q[i] == FREE_E) return i;
         return -1;
      endfunction

      function void note_request(op_type op, logic [63:0] key);
         fs_result_type r;
         int s, b, f, last, nx;
         r = '0;
         s = lookup(key);
         if (op == OP_CREATE) begin
            f = -1;
            for (int i = NDIR - 1; i >= 0; i--) if (!valid_q[i]) f = i;
            b = free_block();
            if (s >= 0) r.status = ST_EXISTS;
            else if (b < 0 || f < 0) r.status = ST_FULL;
            else begin
               valid_q[f] = 1; name_q[f] = key; start_q[f] = b;
               fat_q[b] = UNUSED_E; r.blk = BLKOUT_W'(b);
            end
         end else if (op == OP_APPEND) begin
            if (s < 0) r.status = ST_NOT_FOUND;
            else if (fat_q[start_q[s]] == UNUSED_E) begin
               fat_q[start_q[s]] = END_E; r.blk = BLKOUT_W'(start_q[s]);
            end else begin
               b = free_block();
               if (b < 0) r.status = ST_FULL;
               else begin
                  last = start_q[s];
                  for (int k = 0; k < NBLK; k++) begin
                     if (fat_q[last] >= NBLK) break;
                     last = fat_q[last];
                  end
                  fat_q[b] = END_E; fat_q[last] = b; r.blk = BLKOUT_W'(b);
               end
            end
         end else if (op == OP_DELETE) begin
            if (s < 0) r.status = ST_NOT_FOUND;
            else begin
               b = start_q[s];
               for (int k = 0; k < NBLK; k++) begin
                  nx = fat_q[b];
                  fat_q[b] = FREE_E;
                  if (nx >= NBLK) break;
                  b = nx;
               end
               valid_q[s] = 0;
            end
         end
         pending.push_back(r);
      endfunction

      function void check_response(status_type st, logic [BLKOUT_W-1:0] blk);
         fs_result_type e;
         if (pending.size() == 0) begin
            $error("unexpected response status=%0d block_index=%0d", st, blk);
            fails++;
            return;
         end
         e = pending.pop_front();
         if (st !== e.status) begin
            $error("status: expected %0d, actual %0d", e.status, st); fails++;
         end
         if (blk !== e.blk) begin
            $error("block_index: expected %0d, actual %0d", e.blk, blk); fails++;
         end
      endfunction
   endclass

   logic clock, reset;
   logic req_valid, req_stall, req_deep_erase, rsp_valid, rsp_stall;
   op_type req_operation;
   logic [KEY_W-1:0] req_name_key;
   logic [DATA_W-1:0] req_data_byte;
   status_type rsp_status;
   logic [BLKOUT_W-1:0] rsp_block_index;

   fs_scoreboard sb;
   bit calm, hold_rsp, stim_done;
   int quiet;
   logic [63:0] names[8];

   fat_chain_file_allocator_core dut (.*);

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   task automatic send(op_type op, logic [63:0] key, logic [7:0] d, logic de);
      while (!calm && $urandom_range(99) < 29) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid <= 1; req_operation <= op; req_name_key <= key;
      req_data_byte <= d; req_deep_erase <= de;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_request(op, key);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (sb.pending.size() != 0) @(negedge clock);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_response(rsp_status, rsp_block_index);
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
      else quiet++;
      if (quiet >= LIMIT) begin
         $display("fat_chain_file_allocator_core_tb: errors");
         $finish;
      end
   end

   always @(negedge clock)
      rsp_stall <= hold_rsp || (!calm && $urandom_range(99) < 29);

   initial begin
      int op, n;
      sb = new();
      quiet = 0; calm = 0; hold_rsp = 0; stim_done = 0;
      reset = 1; req_valid = 0; rsp_stall = 0; req_operation = OP_CREATE;
      req_name_key = '0; req_data_byte = '0; req_deep_erase = 0;
      foreach (names[i]) names[i] = {$urandom, $urandom};
      names[0] = '0; names[1] = '1;
      repeat (5) @(posedge clock);
      @(negedge clock); reset = 0;
      // Directed: extremes, missing files, duplicates, reserved operation.
      send(OP_APPEND, names[0], 8'h00, 1'b0);
      send(OP_DELETE, names[1], 8'h00, 1'b1);
      send(OP_CREATE, names[0], 8'h00, 1'b0);
      send(OP_CREATE, names[0], 8'hFF, 1'b1);
      send(OP_CREATE, names[1], 8'hFF, 1'b1);
      send(OP_APPEND, names[0], 8'hFF, 1'b0);
      send(OP_APPEND, names[0], 8'h00, 1'b1);
      send(OP_APPEND, names[1], 8'hA5, 1'b1);
      send(OP_DELETE, names[1], 8'hFF, 1'b1);
      send(OP_DELETE, names[0], 8'h5A, 1'b0);
      send(OP_IGNORED, names[0], 8'hFF, 1'b1);
      send(OP_CREATE, names[1], 8'h00, 1'b0);
      send(OP_DELETE, names[1], 8'h00, 1'b0);
      // Fill the directory until it is full, then release it again.
      for (int i = 0; i < NDIR + 2; i++) send(OP_CREATE, 64'h100 + i, 8'h00, 1'b0);
      for (int i = 0; i < NDIR; i++) send(OP_DELETE, 64'h100 + i, 8'h00, 1'(i));
      // Fill every block through one long chain.
      send(OP_CREATE, names[2], 8'h11, 1'b0);
      for (int i = 0; i < NBLK + 3; i++) send(OP_APPEND, names[2], 8'($urandom), 1'b0);
      send(OP_CREATE, names[3], 8'h00, 1'b0);
      drain();
      send(OP_DELETE, names[2], 8'h00, 1'b1);
      // Receiver holds off while requests keep coming.
      hold_rsp = 1;
      fork
         begin
            repeat (3000) @(negedge clock);
            hold_rsp = 0;
         end
         begin
            for (int i = 0; i < 4; i++) send(OP_CREATE, names[4 + i], 8'h00, 1'b0);
            req_valid <= 0;
         end
      join
      drain();
      for (int i = 0; i < 1000; i++) begin
         calm = (i >= 400 && i < 550);
         n = $urandom_range(7);
         op = $urandom_range(99);
         if (op < 30) send(OP_CREATE, names[n], 8'($urandom), 1'($urandom));
         else if (op < 80) send(OP_APPEND, names[n], 8'($urandom), 1'($urandom));
         else if (op < 96) send(OP_DELETE, names[n], 8'($urandom), 1'($urandom));
         else if (op < 98)
            send(OP_IGNORED, {$urandom, $urandom}, 8'($urandom), 1'($urandom));
         else send(OP_APPEND, {$urandom, $urandom}, 8'($urandom), 1'($urandom));
         if (i == 700) drain();
      end
      calm = 0;
      drain();
      repeat (600) @(negedge clock);
      if (sb.fails == 0 && sb.pending.size() == 0)
         $display("fat_chain_file_allocator_core_tb: clean");
      else
         $display("fat_chain_file_allocator_core_tb: errors");
      $finish;
   end
endmodule
